FILE: hdl/stst_pkg.sv
package stst_pkg;

	localparam int TableDepthDef = 16;
	localparam int NameBytesDef  = 8;

	localparam int FuncW   = 2;
	localparam int ScoreW  = 31;
	localparam int NameW   = 64;
	localparam int RankW   = 5;
	localparam int StatusW = 3;
	localparam int CountW  = 5;

	localparam int InW  = 104;
	localparam int OutW = 104;

	localparam logic [FuncW-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FuncW-1:0] FUNC_DELETE = 2'd1;
	localparam logic [FuncW-1:0] FUNC_READ   = 2'd2;

	localparam logic [StatusW-1:0] ST_DONE    = 3'd0;
	localparam logic [StatusW-1:0] ST_LOW     = 3'd1;
	localparam logic [StatusW-1:0] ST_BADRANK = 3'd2;
	localparam logic [StatusW-1:0] ST_EMPTY   = 3'd3;
	localparam logic [StatusW-1:0] ST_CANCEL  = 3'd4;

	typedef struct packed {
		logic [ScoreW-1:0] score;
		logic [NameW-1:0]  name;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic del;
	} cmd_t;

endpackage

FILE: hdl/stst_cell.sv
module stst_cell #(
	parameter int TABLE_DEPTH = stst_pkg::TableDepthDef,
	parameter int IDX         = 0
) (
	input  logic                                   clk,
	input  stst_pkg::cmd_t                         cmd,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]       count,
	input  logic [stst_pkg::RankW-1:0]             rank,
	input  stst_pkg::entry_t                       new_ent,
	input  stst_pkg::entry_t                       prev_ent,
	input  logic                                   prev_ge,
	input  stst_pkg::entry_t                       next_ent,
	output stst_pkg::entry_t                       ent,
	output logic                                   ge,
	output stst_pkg::entry_t                       rd_ent
);
	import stst_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = ((CW > RankW) ? CW : RankW) + 1;

	entry_t         ent_q;
	logic           valid;
	logic           at_or_past;
	logic           hit;
	logic [RW-1:0]  my_idx;
	logic [RW-1:0]  my_pos;
	logic [RW-1:0]  cnt_w;
	logic [RW-1:0]  rank_w;

	assign my_idx = RW'(IDX);
	assign my_pos = RW'(IDX + 1);
	assign cnt_w  = RW'(count);
	assign rank_w = RW'(rank);

	assign valid      = my_idx < cnt_w;
	assign ge         = valid && (ent_q.score >= new_ent.score);
	assign at_or_past = my_pos >= rank_w;
	assign hit        = my_pos == rank_w;

	assign ent    = ent_q;
	assign rd_ent = hit ? ent_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!ge) begin
				ent_q <= prev_ge ? new_ent : prev_ent;
			end
		end else if (cmd.del) begin
			if (at_or_past) begin
				ent_q <= next_ent;
			end
		end
	end

endmodule

FILE: hdl/sorted_top_n_score_table_unit.sv
// The result transaction is registered and is valid in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle while the result is taken (m_tready); insert, delete and read each finish in a
// single pass over the row of compare-and-shift cells.
// Reset: arst_n clears the entry count and the output valid; cell contents
// are not cleared and are only seen below the entry count.
module sorted_top_n_score_table_unit #(
	parameter int TABLE_DEPTH = stst_pkg::TableDepthDef,
	parameter int NAME_BYTES  = stst_pkg::NameBytesDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// func[1:0], new_score[32:2], new_name[96:33], rank[101:97], zero[103:102]
	input  logic [stst_pkg::InW-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status[2:0], entry_count[7:3], read_score[38:8], read_name[102:39], zero[103]
	output logic [stst_pkg::OutW-1:0]  m_tdata
);
	import stst_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = ((CW > RankW) ? CW : RankW) + 1;

	logic [FuncW-1:0]   func;
	logic [ScoreW-1:0]  new_score;
	logic [NameW-1:0]   new_name;
	logic [RankW-1:0]   rank;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_nxt;
	logic               m_tvalid_q;
	logic [OutW-1:0]    m_tdata_q;

	logic               accept;
	logic               empty;
	logic               full;
	logic               rank_ok;
	logic [RW-1:0]      rank_w;
	logic [RW-1:0]      cnt_w;
	logic [StatusW-1:0] status;
	logic               is_read_ok;
	cmd_t               cmd;
	entry_t             new_ent;
	entry_t             rd_all;
	entry_t             rd_out;
	logic [NameW-1:0]   packed_name;

	entry_t             ents [TABLE_DEPTH];
	entry_t             rds  [TABLE_DEPTH];
	logic               ges  [TABLE_DEPTH];

	assign func      = s_tdata[1:0];
	assign new_score = s_tdata[32:2];
	assign new_name  = s_tdata[96:33];
	assign rank      = s_tdata[101:97];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		logic alive;
		alive       = 1'b1;
		packed_name = '0;
		for (int b = 0; b < 8; b++) begin
			if (b >= NAME_BYTES || new_name[8*b +: 8] == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				packed_name[8*b +: 8] = new_name[8*b +: 8];
			end
		end
	end

	assign new_ent.score = new_score;
	assign new_ent.name  = packed_name;

	assign empty   = count_q == '0;
	assign full    = count_q == CW'(TABLE_DEPTH);
	assign rank_w  = RW'(rank);
	assign cnt_w   = RW'(count_q);
	assign rank_ok = (rank != '0) && (rank_w <= cnt_w);

	always_comb begin
		status     = ST_DONE;
		cmd        = '0;
		count_nxt  = count_q;
		is_read_ok = 1'b0;
		unique case (func) inside
			FUNC_INSERT: begin
				if (full && ges[TABLE_DEPTH-1]) begin
					status = ST_LOW;
				end else begin
					cmd.ins = accept;
					if (!full) begin
						count_nxt = count_q + 1'b1;
					end
				end
			end
			FUNC_DELETE, FUNC_READ: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (rank == '0) begin
					status = ST_CANCEL;
				end else if (!rank_ok) begin
					status = ST_BADRANK;
				end else if (func == FUNC_DELETE) begin
					cmd.del   = accept;
					count_nxt = count_q - 1'b1;
				end else begin
					is_read_ok = 1'b1;
				end
			end
			default: begin
				status = ST_BADRANK;
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			entry_t prev_e;
			entry_t next_e;
			logic   prev_g;
			if (gi == 0) begin : g_first
				assign prev_e = new_ent;
				assign prev_g = 1'b1;
			end else begin : g_mid
				assign prev_e = ents[gi-1];
				assign prev_g = ges[gi-1];
			end
			if (gi == TABLE_DEPTH - 1) begin : g_last
				assign next_e = ents[gi];
			end else begin : g_inner
				assign next_e = ents[gi+1];
			end
			stst_cell #(
				.TABLE_DEPTH(TABLE_DEPTH),
				.IDX        (gi)
			) u_cell (
				.clk     (clk),
				.cmd     (cmd),
				.count   (count_q),
				.rank    (rank),
				.new_ent (new_ent),
				.prev_ent(prev_e),
				.prev_ge (prev_g),
				.next_ent(next_e),
				.ent     (ents[gi]),
				.ge      (ges[gi]),
				.rd_ent  (rds[gi])
			);
		end
	endgenerate

	always_comb begin
		rd_all = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			rd_all = rd_all | rds[i];
		end
	end

	assign rd_out = is_read_ok ? rd_all : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {1'b0, rd_out.name, rd_out.score, CountW'(count_nxt), status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: dv/sorted_top_n_score_table_unit_tb.sv
module sorted_top_n_score_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stst_pkg::*;

	localparam int DEPTH = TableDepthDef;
	localparam int NAME_BYTES = NameBytesDef;
	localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [ScoreW-1:0] SCORE_MAX = {ScoreW{1'b1}};
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [InW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OutW-1:0] m_tdata;

	logic [InW-1:0] op_queue[$];
	logic [OutW-1:0] reply_queue[$];

	logic [ScoreW-1:0] tbl_score[DEPTH];
	logic [NameW-1:0] tbl_name[DEPTH];
	int tbl_cnt = 0;
	int gen_cnt = 0;

	int src_idle = 0;
	int snk_idle = 0;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;
	int stall_cycles = 0;
	int err_cnt = 0;

	sorted_top_n_score_table_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	initial begin
		for (int k = 0; k < DEPTH; k++) begin
			tbl_score[k] = '0;
			tbl_name[k] = '0;
		end
	end

	// bounded string copy of the name
	function automatic logic [NameW-1:0] trim_name(input logic [NameW-1:0] raw);
		logic [NameW-1:0] kept;
		logic stop;
		kept = '0;
		stop = 1'b0;
		for (int b = 0; b < NAME_BYTES && b < 8; b++) begin
			if (raw[8*b +: 8] == 8'h00)
				stop = 1'b1;
			if (!stop)
				kept[8*b +: 8] = raw[8*b +: 8];
		end
		return kept;
	endfunction

	function automatic logic [OutW-1:0] apply_table_op(input logic [InW-1:0] d);
		logic [FuncW-1:0] f;
		logic [ScoreW-1:0] sc;
		logic [NameW-1:0] nm;
		int rk;
		int pos;
		logic [StatusW-1:0] st;
		logic [ScoreW-1:0] rs;
		logic [NameW-1:0] rn;
		logic [CountW-1:0] cnt;
		f = d[1:0];
		sc = d[32:2];
		nm = trim_name(d[96:33]);
		rk = int'(d[101:97]);
		st = ST_DONE;
		rs = '0;
		rn = '0;
		if (f == FUNC_INSERT) begin
			if (tbl_cnt == DEPTH && sc <= tbl_score[DEPTH-1]) begin
				st = ST_LOW;
			end else begin
				if (tbl_cnt == DEPTH)
					tbl_cnt = DEPTH - 1;
				pos = 0;
				while (pos < tbl_cnt && tbl_score[pos] >= sc)
					pos++;
				for (int k = tbl_cnt; k > pos; k--) begin
					tbl_score[k] = tbl_score[k-1];
					tbl_name[k] = tbl_name[k-1];
				end
				tbl_score[pos] = sc;
				tbl_name[pos] = nm;
				tbl_cnt++;
			end
		end else if (f == FUNC_DELETE || f == FUNC_READ) begin
			if (tbl_cnt == 0) begin
				st = ST_EMPTY;
			end else if (rk == 0) begin
				st = ST_CANCEL;
			end else if (rk > tbl_cnt) begin
				st = ST_BADRANK;
			end else if (f == FUNC_DELETE) begin
				for (int k = rk - 1; k + 1 < tbl_cnt; k++) begin
					tbl_score[k] = tbl_score[k+1];
					tbl_name[k] = tbl_name[k+1];
				end
				tbl_cnt--;
			end else begin
				rs = tbl_score[rk-1];
				rn = tbl_name[rk-1];
			end
		end else begin
			st = ST_BADRANK;
		end
		cnt = tbl_cnt[CountW-1:0];
		return {1'b0, rn, rs, cnt, st};
	endfunction

	task automatic push_op(input logic [FuncW-1:0] f, input logic [ScoreW-1:0] sc,
			input logic [NameW-1:0] nm, input logic [RankW-1:0] rk);
		op_queue.push_back({2'b00, rk, nm, sc, f});
		if (f == FUNC_INSERT && gen_cnt < DEPTH)
			gen_cnt++;
		else if (f == FUNC_DELETE && rk != 0 && rk <= gen_cnt)
			gen_cnt--;
	endtask

	task automatic gen_random(input int n);
		int roll;
		int fill_bias;
		logic [FuncW-1:0] f;
		logic [ScoreW-1:0] sc;
		logic [NameW-1:0] nm;
		logic [RankW-1:0] rk;
		fill_bias = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 80 == 0)
				fill_bias = $urandom_range(25, 75);
			roll = $urandom_range(99);
			if (roll < 2)
				f = FUNC_UNUSED;
			else if (roll < fill_bias)
				f = FUNC_INSERT;
			else if ($urandom_range(1) == 0)
				f = FUNC_DELETE;
			else
				f = FUNC_READ;
			case ($urandom_range(9))
				0: sc = '0;
				1: sc = SCORE_MAX;
				2, 3, 4, 5: sc = ScoreW'($urandom_range(0, 20));
				6, 7: sc = ScoreW'($urandom_range(1000, 1010));
				default: sc = ScoreW'($urandom);
			endcase
			nm = {$urandom, $urandom};
			if ($urandom_range(3) == 0)
				nm[8*$urandom_range(7) +: 8] = 8'h00;
			if ($urandom_range(19) == 0)
				nm = '0;
			roll = $urandom_range(99);
			if (roll < 6)
				rk = '0;
			else if (roll < 14)
				rk = RankW'($urandom_range(gen_cnt + 1, 31));
			else if (gen_cnt == 0)
				rk = RankW'($urandom_range(31));
			else
				rk = RankW'($urandom_range(1, gen_cnt));
			push_op(f, sc, nm, rk);
		end
	endtask

	task automatic wait_drain();
		while (op_queue.size() != 0 || s_tvalid || reply_queue.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				reply_queue.push_back(apply_table_op(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (op_queue.size() != 0 && $urandom_range(99) >= src_idle) begin
					s_tdata <= op_queue.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		logic [OutW-1:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reply_queue.size() == 0) begin
					$error("unexpected result transaction %h", m_tdata);
					err_cnt++;
				end else begin
					want = reply_queue.pop_front();
					if (m_tdata[2:0] !== want[2:0]) begin
						$error("status: expected %0d, got %0d", want[2:0], m_tdata[2:0]);
						err_cnt++;
					end
					if (m_tdata[7:3] !== want[7:3]) begin
						$error("entry_count: expected %0d, got %0d", want[7:3], m_tdata[7:3]);
						err_cnt++;
					end
					if (m_tdata[38:8] !== want[38:8]) begin
						$error("read_score: expected %0d, got %0d", want[38:8], m_tdata[38:8]);
						err_cnt++;
					end
					if (m_tdata[102:39] !== want[102:39]) begin
						$error("read_name: expected %h, got %h", want[102:39], m_tdata[102:39]);
						err_cnt++;
					end
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_done != hold_asked) begin
				m_tready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= hold_done + 1;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles == WATCHDOG) begin
				$display("sorted_top_n_score_table_unit verification failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		push_op(FUNC_READ, '0, '0, 5'd3);
		push_op(FUNC_DELETE, '0, '0, 5'd0);
		push_op(FUNC_READ, '0, '0, 5'd0);
		// extremes, name truncation, ties, rank ignored on insert
		push_op(FUNC_INSERT, SCORE_MAX, {NameW{1'b1}}, 5'd31);
		push_op(FUNC_INSERT, '0, '0, 5'd0);
		push_op(FUNC_INSERT, 31'd100, 64'h4847_4600_4443_4241, 5'd7);
		push_op(FUNC_INSERT, 31'd100, 64'hFFFF_FFFF_FFFF_FF00, 5'd1);
		push_op(FUNC_INSERT, 31'd100, 64'h0102_0304_0506_0708, 5'd16);
		for (int r = 1; r <= 5; r++)
			push_op(FUNC_READ, '0, '0, r[RankW-1:0]);
		push_op(FUNC_READ, '0, '0, 5'd6);
		push_op(FUNC_READ, '0, '0, 5'd31);
		push_op(FUNC_READ, '0, '0, 5'd0);
		push_op(FUNC_DELETE, '0, '0, 5'd0);
		push_op(FUNC_DELETE, '0, '0, 5'd31);
		push_op(FUNC_DELETE, '0, '0, 5'd2);
		push_op(FUNC_DELETE, '0, '0, 5'd4);
		push_op(FUNC_READ, '0, '0, 5'd3);
		push_op(FUNC_UNUSED, SCORE_MAX, {NameW{1'b1}}, 5'd1);
		push_op(FUNC_INSERT, 31'h5555_5555, 64'hA5A5_A5A5_5A5A_5A5A, 5'd0);
		push_op(FUNC_READ, '0, '0, 5'd1);
		wait_drain();

		src_idle <= 0;
		snk_idle <= 0;
		gen_random(400);
		wait_drain();

		src_idle <= 60;
		snk_idle <= 0;
		gen_random(400);
		wait_drain();

		src_idle <= 0;
		snk_idle <= 60;
		gen_random(400);
		wait_drain();

		src_idle <= 21;
		snk_idle <= 21;
		gen_random(400);
		wait_drain();

		// long receiver hold-off with the sender running flat out
		src_idle <= 0;
		snk_idle <= 0;
		hold_asked <= hold_asked + 1;
		gen_random(60);
		wait_drain();

		if (err_cnt == 0)
			$display("sorted_top_n_score_table_unit verification clean");
		else
			$display("sorted_top_n_score_table_unit verification failed");
		$finish;
	end

endmodule
